// ===== design/box_corner_projection_bbox_core_macros.svh =====
// Assertion macros for the box corner projection bounding box core.
// Used by the checker bound to the top level.
`ifndef BOX_CORNER_PROJECTION_BBOX_CORE_MACROS_SVH
`define BOX_CORNER_PROJECTION_BBOX_CORE_MACROS_SVH

// Check a property while out of reset.
`define BCP_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error("assertion failed");

// Check a property at every edge, reset included.
`define BCP_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) else $error("assertion failed");

`endif

// ===== design/bcp_pkg.sv =====
// Shared types and constants for the box corner projection bounding box core.
// No dependencies.
`timescale 1ns / 1ps
package bcp_pkg;
  localparam int COEF_WORDS = 20;
  localparam int WORLD_BASE = 12;
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_CORNER = 1'b1;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_clr;
    logic is_const;
  } mac_ctl_t;

  // first store word of each matrix row, in processing order
  function automatic logic [4:0] row_base(input logic [2:0] seq);
    logic [4:0] b;
    case (seq)
      3'd0: b = 5'(WORLD_BASE);
      3'd1: b = 5'(WORLD_BASE + 4);
      3'd2: b = 5'd0;
      3'd3: b = 5'd4;
      default: b = 5'd8;
    endcase
    return b;
  endfunction
endpackage

// ===== design/bcp_mac.sv =====
// Shared 32x32 multiplier with saturating 64-bit accumulator.
// Depends on bcp_pkg.
`timescale 1ns / 1ps
module bcp_mac
  import bcp_pkg::*;
(
  input  logic               clk,
  input  mac_ctl_t           ctl,
  input  logic signed [31:0] coef,
  input  logic signed [31:0] opnd,
  output logic signed [63:0] acc
);
  logic signed [63:0] prod_w;
  logic signed [63:0] prod_r;
  logic signed [63:0] acc_r;
  logic signed [63:0] base_w;
  logic        [64:0] sum_w;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end
    return s[63:0];
  endfunction

  assign prod_w = coef * opnd;
  assign base_w = ctl.acc_clr ? 64'sd0 : acc_r;
  assign sum_w  = {1'b0, sat_add(base_w, prod_r)};

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= ctl.is_const ? {{16{coef[31]}}, coef, 16'h0000} : prod_w;
    end
    if (ctl.acc_en) begin
      acc_r <= sum_w[63:0];
    end
  end

  assign acc = acc_r;
endmodule

// ===== design/bcp_div.sv =====
// Serial restoring divider, one quotient bit a cycle, with rounding half
// away from zero and 16-bit saturation. Depends on bcp_pkg.
`timescale 1ns / 1ps
module bcp_div
  import bcp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic               done,
  output logic signed [15:0] pix,
  output logic               fault
);
  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_FIN  = 2'd2;

  logic [1:0]         st_r;
  logic [6:0]         cnt_r;
  logic [63:0]        quo_r;
  logic [63:0]        rem_r;
  logic [63:0]        ud_r;
  logic               neg_r;
  logic signed [15:0] pix_r;
  logic               fault_r;
  logic               done_r;
  logic [64:0]        rem_sh;
  logic               ge;
  logic [64:0]        rem_sub;
  logic [63:0]        q_nxt;

  assign rem_sh  = {rem_r, quo_r[63]};
  assign ge      = rem_sh >= {1'b0, ud_r};
  assign rem_sub = rem_sh - {1'b0, ud_r};
  assign q_nxt   = quo_r + 64'({rem_r, 1'b0} >= {1'b0, ud_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        D_IDLE: begin
          if (start) begin
            if (den == 64'sd0) begin
              pix_r   <= (num > 64'sd0) ? 16'sh7FFF : (num[63] ? 16'sh8000 : 16'sh0000);
              fault_r <= 1'b1;
              done_r  <= 1'b1;
            end else begin
              quo_r <= num[63] ? 64'(-num) : num;
              ud_r  <= den[63] ? 64'(-den) : den;
              rem_r <= 64'd0;
              neg_r <= num[63] ^ den[63];
              cnt_r <= 7'd64;
              st_r  <= D_RUN;
            end
          end
        end
        D_RUN: begin
          rem_r <= ge ? rem_sub[63:0] : rem_sh[63:0];
          quo_r <= {quo_r[62:0], ge};
          cnt_r <= cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            st_r <= D_FIN;
          end
        end
        D_FIN: begin
          if (neg_r) begin
            pix_r <= (q_nxt > 64'd32768) ? 16'sh8000 : 16'(16'd0 - q_nxt[15:0]);
          end else begin
            pix_r <= (q_nxt > 64'd32767) ? 16'sh7FFF : q_nxt[15:0];
          end
          fault_r <= 1'b0;
          done_r  <= 1'b1;
          st_r    <= D_IDLE;
        end
        default: st_r <= D_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign pix   = pix_r;
  assign fault = fault_r;
endmodule

// ===== design/box_corner_projection_bbox_core.sv =====
// Box corner projection bounding box core; uses bcp_pkg, bcp_mac and bcp_div.
// Load word: core stays ready. Corner word: in_tready low from the accept until the corner
// is done (longer on a box's last corner, and while a rectangle waits on out_tready):
// 5 rows of 4 multiply-accumulate terms on one multiplier, then two serial divisions
// (shorter at zero depth); the rectangle is valid once the box's last corner is done.
// rst_n: synchronous, active low; clears control and output valid, not the coef store.
`timescale 1ns / 1ps
module box_corner_projection_bbox_core
  import bcp_pkg::*;
#(
  parameter int CORNER_COUNT = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // coef_index, coef_value, corner_x, corner_y, corner_z, loc_x, loc_y, loc_z, pad
  input  logic [231:0] in_tdata,
  // command
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // box_left, box_top, box_width, box_height
  output logic [63:0]  out_tdata,
  // depth_fault
  output logic [0:0]   out_tuser
);
  localparam int CW = (CORNER_COUNT > 1) ? $clog2(CORNER_COUNT) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_ACC  = 4'd2;
  localparam logic [3:0] S_ROW  = 4'd3;
  localparam logic [3:0] S_DSU  = 4'd4;
  localparam logic [3:0] S_DWU  = 4'd5;
  localparam logic [3:0] S_DSV  = 4'd6;
  localparam logic [3:0] S_DWV  = 4'd7;
  localparam logic [3:0] S_UPD  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]         st_r;
  logic [1:0]         term_r;
  logic [2:0]         seq_r;
  logic [CW-1:0]      cnt_r;
  logic signed [31:0] coef_store [COEF_WORDS];
  logic signed [31:0] cx_r, cy_r, cz_r, wx_r, wy_r, wz_r;
  logic signed [31:0] px_r, py_r;
  logic signed [63:0] u_r, v_r, w_r;
  logic signed [15:0] col_r, row_r;
  logic signed [15:0] cmin_r, cmax_r, rmin_r, rmax_r;
  logic signed [15:0] cmin_nxt, cmax_nxt, rmin_nxt, rmax_nxt;
  logic               fault_seen_r;
  logic               out_valid_r;
  logic [63:0]        out_data_r;
  logic               out_fault_r;
  logic               accept;
  logic [4:0]         idx_in;
  logic               first;
  logic               last;
  logic [CW:0]        cnt_inc;
  mac_ctl_t           mac_ctl;
  logic signed [31:0] coef_rd;
  logic signed [31:0] opnd;
  logic signed [63:0] acc;
  logic signed [31:0] q16_w;
  logic signed [31:0] pt_w;
  logic               div_start;
  logic               div_done;
  logic signed [15:0] div_pix;
  logic               div_fault;

  function automatic logic signed [31:0] to_q16(input logic signed [63:0] x);
    logic [63:0] m;
    logic [48:0] q;
    m = x[63] ? 64'(-x) : x;
    q = {1'b0, m[63:16]} + 49'(m[15]);
    if (x[63]) begin
      return (q > 49'h0_8000_0000) ? 32'sh8000_0000 : 32'(49'd0 - q);
    end
    return (q > 49'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
  endfunction

  function automatic logic signed [31:0] add_sat32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  assign in_tready = (st_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign idx_in    = in_tdata[4:0];

  assign mac_ctl.mul_en   = (st_r == S_MUL);
  assign mac_ctl.acc_en   = (st_r == S_ACC);
  assign mac_ctl.acc_clr  = (term_r == 2'd0);
  assign mac_ctl.is_const = (term_r == 2'd3);

  assign coef_rd = coef_store[row_base(seq_r) + 5'(term_r)];

  always_comb begin
    case (term_r)
      2'd0:    opnd = (seq_r < 3'd2) ? wx_r : px_r;
      2'd1:    opnd = (seq_r < 3'd2) ? wy_r : py_r;
      default: opnd = (seq_r < 3'd2) ? wz_r : cz_r;
    endcase
  end

  assign q16_w = to_q16(acc);
  assign pt_w  = add_sat32((seq_r == 3'd0) ? cx_r : cy_r, q16_w);

  assign div_start = (st_r == S_DSU) || (st_r == S_DSV);

  assign first    = (cnt_r == '0);
  assign cmin_nxt = (first || col_r < cmin_r) ? col_r : cmin_r;
  assign cmax_nxt = (first || col_r > cmax_r) ? col_r : cmax_r;
  assign rmin_nxt = (first || row_r < rmin_r) ? row_r : rmin_r;
  assign rmax_nxt = (first || row_r > rmax_r) ? row_r : rmax_r;
  assign cnt_inc  = {1'b0, cnt_r} + (CW+1)'(1);
  assign last     = cnt_inc >= (CW+1)'(CORNER_COUNT);

  bcp_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .coef (coef_rd),
    .opnd (opnd),
    .acc  (acc)
  );

  bcp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ((st_r == S_DSU) ? u_r : v_r),
    .den   (w_r),
    .done  (div_done),
    .pix   (div_pix),
    .fault (div_fault)
  );

  always_ff @(posedge clk) begin
    if (accept && in_tuser[0] == CMD_LOAD && idx_in < 5'(COEF_WORDS)) begin
      coef_store[idx_in] <= in_tdata[36:5];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      term_r       <= 2'd0;
      seq_r        <= 3'd0;
      cnt_r        <= '0;
      cmin_r       <= '0;
      cmax_r       <= '0;
      rmin_r       <= '0;
      rmax_r       <= '0;
      fault_seen_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && st_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (accept && in_tuser[0] == CMD_CORNER) begin
            cx_r   <= in_tdata[68:37];
            cy_r   <= in_tdata[100:69];
            cz_r   <= in_tdata[132:101];
            wx_r   <= in_tdata[164:133];
            wy_r   <= in_tdata[196:165];
            wz_r   <= in_tdata[228:197];
            term_r <= 2'd0;
            seq_r  <= 3'd0;
            st_r   <= S_MUL;
          end
        end
        S_MUL: st_r <= S_ACC;
        S_ACC: begin
          term_r <= term_r + 2'd1;
          st_r   <= (term_r == 2'd3) ? S_ROW : S_MUL;
        end
        S_ROW: begin
          case (seq_r)
            3'd0:    px_r <= pt_w;
            3'd1:    py_r <= pt_w;
            3'd2:    u_r  <= acc;
            3'd3:    v_r  <= acc;
            default: w_r  <= acc;
          endcase
          seq_r <= seq_r + 3'd1;
          st_r  <= (seq_r == 3'd4) ? S_DSU : S_MUL;
        end
        S_DSU: st_r <= S_DWU;
        S_DWU: begin
          if (div_done) begin
            col_r        <= div_pix;
            fault_seen_r <= fault_seen_r | div_fault;
            st_r         <= S_DSV;
          end
        end
        S_DSV: st_r <= S_DWV;
        S_DWV: begin
          if (div_done) begin
            row_r        <= div_pix;
            fault_seen_r <= fault_seen_r | div_fault;
            st_r         <= S_UPD;
          end
        end
        S_UPD: begin
          cmin_r <= cmin_nxt;
          cmax_r <= cmax_nxt;
          rmin_r <= rmin_nxt;
          rmax_r <= rmax_nxt;
          cnt_r  <= last ? '0 : cnt_inc[CW-1:0];
          st_r   <= last ? S_OUT : S_IDLE;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_data_r   <= {16'(rmax_r - rmin_r), 16'(cmax_r - cmin_r), rmin_r, cmin_r};
            out_fault_r  <= fault_seen_r;
            out_valid_r  <= 1'b1;
            fault_seen_r <= 1'b0;
            st_r         <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_fault_r;
endmodule

// ===== design/bcp_checker.sv =====
// Port checker for the box corner projection bounding box core, bound to the top level.
// Depends on bcp_pkg and box_corner_projection_bbox_core_macros.svh.
`timescale 1ns / 1ps
`include "box_corner_projection_bbox_core_macros.svh"
module bcp_checker
  import bcp_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [231:0] in_tdata,
  input logic [0:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [63:0]  out_tdata,
  input logic [0:0]   out_tuser
);
  `BCP_ASSERT_ALWAYS(a_rst_no_out, clk, !rst_n |=> !out_tvalid)
  `BCP_ASSERT(a_corner_busy, clk, rst_n, (in_tvalid && in_tready && in_tuser[0] == CMD_CORNER) |=> !in_tready)
  `BCP_ASSERT(a_load_ready, clk, rst_n, (in_tvalid && in_tready && in_tuser[0] == CMD_LOAD) |=> in_tready)
  `BCP_ASSERT(a_out_hold, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
endmodule

bind box_corner_projection_bbox_core bcp_checker u_bcp_checker (.*);
